@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the time sync RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ptsc_pkg.sv @@
// Types and constants of the timestamp to caption time block.
`default_nettype none

package ptsc_pkg;

	localparam int PTS_W   = 33;
	localparam int SYNC_W  = 35;
	localparam int OP_W    = 36;
	localparam int CLK_W   = 24;
	localparam int DIV_W   = 46;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int FRAC_W  = 16;
	localparam int FT_W    = 10 + MUL_B_W - FRAC_W;
	localparam int CFG_W   = 48;
	localparam int OUT_W   = 48;

	localparam logic [PTS_W-1:0] PTS_NONE = '1;

	localparam logic [6:0] UNKNOWN_LIMIT = 7'd100;
	localparam int GAP_LIMIT_MS = 100;
	localparam int MS_PER_S     = 1000;
	localparam int CAP_NUM      = 1001;
	localparam int CAP_DEN      = 30;

	localparam logic [1:0] REQ_FRAME   = 2'd0;
	localparam logic [1:0] REQ_CAPTION = 2'd1;
	localparam logic [1:0] REQ_START   = 2'd2;
	localparam logic [1:0] REQ_END     = 2'd3;

	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_I       = 2'd1;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_RCVD = 2'd1;
	localparam logic [1:0] PH_MIN  = 2'd2;

	localparam logic [2:0] CFG_SYNC_OFF    = 3'd1;
	localparam logic [2:0] CFG_RESYNC_OFF  = 3'd2;
	localparam logic [2:0] CFG_MAX_GAP     = 3'd3;
	localparam logic [2:0] CFG_CLOCK_HZ    = 3'd4;
	localparam logic [2:0] CFG_FRAME_TICKS = 3'd5;
	localparam logic [2:0] CFG_FRAME_MS    = 3'd6;
	localparam logic [2:0] CFG_GLOBAL_OFS  = 3'd7;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CLK_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

@@ rtl/core/ptsc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module ptsc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ptsc_pkg::div_req_t            req,
	output logic                               done,
	output logic [ptsc_pkg::DIV_W-1:0]         quot
);

	localparam int DW = ptsc_pkg::DIV_W;
	localparam int VW = ptsc_pkg::CLK_W;
	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/ptsc_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module ptsc_mul (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire ptsc_pkg::mul_req_t                            req,
	output logic                                               done,
	output logic [ptsc_pkg::PROD_W-ptsc_pkg::FRAC_W-1:0]       prod
);

	localparam int AW = ptsc_pkg::MUL_A_W;
	localparam int BW = ptsc_pkg::MUL_B_W;
	localparam int PW = ptsc_pkg::PROD_W;
	localparam int CW = $clog2(BW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_q;
	logic [PW-1:0] p_q;
	logic [AW:0]   upper;

	assign upper = {1'b0, p_q[PW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			p_q <= {{AW{1'b0}}, req.b};
		end else if (busy_q) begin
			p_q <= {upper, p_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q[PW-1:ptsc_pkg::FRAC_W];

endmodule

`default_nettype wire

@@ rtl/core/pts_to_caption_time_sync.sv @@
// Top level: timestamp to caption time sequencer with shared divider and multiplier.
// A frame item (req_type 0) runs the timeline rules on a small sequencer that shares one
// bit-serial divider (for each tick-to-ms conversion) and one bit-serial multiplier
// (for each frame-count conversion). A frame that needs no conversion uses neither unit;
// in the worst case the jump check, minimum check, resync and current time all convert.
// A visible start or end query uses neither unit, and a caption time query with a field
// set is bound by the divider. The block holds in_stall high from acceptance until its
// result is loaded into the output register; that register then waits for the downstream
// side while the next item is accepted.
`default_nettype none
`include "assert_macros.svh"

module pts_to_caption_time_sync #(
	parameter int TIME_BITS = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          req_type,
	input  wire logic [32:0]         pts,
	input  wire logic [9:0]          temporal_ref,
	input  wire logic [1:0]          picture_kind,
	input  wire logic [15:0]         frames_since_ref,
	input  wire logic [31:0]         total_frames,
	input  wire logic [1:0]          caption_field,
	input  wire logic [15:0]         caption_blocks,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     ok,
	output logic                     jump_seen,
	output logic signed [47:0]       time_ms,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [47:0]         cfg_data
);

	localparam int TB  = TIME_BITS;
	localparam int XW  = ptsc_pkg::PROD_W;
	localparam int QW  = ptsc_pkg::DIV_W + 1;
	localparam int PW  = ptsc_pkg::PTS_W;
	localparam int SW  = ptsc_pkg::SYNC_W;
	localparam int OW  = ptsc_pkg::OP_W;
	localparam int DW  = ptsc_pkg::DIV_W;
	localparam int AW  = ptsc_pkg::MUL_A_W;
	localparam int FW  = ptsc_pkg::FT_W;
	localparam int MPW = ptsc_pkg::PROD_W - ptsc_pkg::FRAC_W;
	localparam int GW  = 27;

	localparam logic signed [TB-1:0] TMAX = {1'b0, {(TB-1){1'b1}}};
	localparam logic signed [TB-1:0] TMIN = {1'b1, {(TB-1){1'b0}}};
	localparam logic signed [XW-1:0] XMAX = XW'(TMAX);
	localparam logic signed [XW-1:0] XMIN = XW'(TMIN);
	localparam logic signed [QW-1:0] NEG_SEC = QW'(-ptsc_pkg::MS_PER_S);
	localparam logic signed [QW-1:0] GAP_MS  = QW'(ptsc_pkg::GAP_LIMIT_MS);
	localparam logic [SW-1:0] BASE_NONE = {2'b00, ptsc_pkg::PTS_NONE};

	typedef enum logic [4:0] {
		ST_IDLE, ST_JCHK, ST_JDEC, ST_BADJ, ST_MIN, ST_MINDEC, ST_BASE, ST_OFSDEC,
		ST_RS, ST_RSDIV, ST_RSMUL, ST_TREF, ST_NOWDEC, ST_MAX, ST_QRY, ST_QCAP,
		ST_DIV_GO, ST_DIV_WAIT, ST_MUL_GO, ST_MUL_WAIT, ST_DONE
	} state_t;

	function automatic logic signed [TB-1:0] clampx(input logic signed [XW-1:0] x);
		logic signed [TB-1:0] r;
		if (x > XMAX) r = TMAX;
		else if (x < XMIN) r = TMIN;
		else r = x[TB-1:0];
		return r;
	endfunction

	function automatic logic signed [TB-1:0] sat_add(input logic signed [TB-1:0] a,
		input logic signed [TB-1:0] b);
		logic signed [TB:0]   s;
		logic signed [TB-1:0] r;
		s = {a[TB-1], a} + {b[TB-1], b};
		if (s[TB] != s[TB-1]) r = s[TB] ? TMIN : TMAX;
		else r = s[TB-1:0];
		return r;
	endfunction

	// configuration
	logic        sync_off_q;
	logic        resync_off_q;
	logic [15:0] max_gap_q;
	logic [23:0] clock_hz_q;
	logic [31:0] frame_ticks_q;
	logic [31:0] frame_ms_q;
	logic signed [TB-1:0] goff_q;

	// sequencer and timeline state
	state_t               state_q;
	state_t               ret_q;
	logic [PW-1:0]        cur_q;
	logic [1:0]           phase_q;
	logic                 wb_q;
	logic signed [SW-1:0] sync_q;
	logic signed [SW-1:0] base_q;
	logic                 badj_q;
	logic [PW-1:0]        lowest_q;
	logic                 kts_q;
	logic [6:0]           ucnt_q;
	logic signed [TB-1:0] now_q;
	logic signed [TB-1:0] max_q;
	logic signed [TB-1:0] offset_q;
	logic signed [TB-1:0] floor_q;
	logic                 jump_q;
	logic signed [TB-1:0] res_q;
	logic signed [OW-1:0] op_q;
	logic                 div_cap_q;
	logic                 div_neg_q;
	logic signed [QW-1:0] quo_q;
	logic [AW-1:0]        mul_a_q;
	logic                 mul_neg_q;
	logic signed [TB-1:0] fm_q;
	logic [PW-1:0]        cand_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic                 jump_out_q;
	logic signed [TB-1:0] time_q;

	// captured item
	logic [1:0]    req_q;
	logic [9:0]    tref_q;
	logic [1:0]    kind_q;
	logic [15:0]   fsr_q;
	logic [31:0]   total_q;
	logic          fld_set_q;
	logic [15:0]   cap_cnt_q;
	logic [FW-1:0] ft_q;

	// shared units
	ptsc_pkg::div_req_t div_req;
	ptsc_pkg::mul_req_t mul_req;
	logic               div_done;
	logic [DW-1:0]      div_quot;
	logic               mul_done;
	logic [MPW-1:0]     mul_prod;

	logic                 accept;
	logic                 div_zero;
	logic [OW-1:0]        op_mag;
	logic [PW-1:0]        newlow;
	logic [6:0]           newu;
	logic                 canbase;
	logic [GW-1:0]        gap_ms;
	logic signed [QW-1:0] gap_lim;
	logic                 jump_now;
	logic signed [TB-1:0] t_now;
	logic signed [SW-1:0] cur_s;
	logic signed [SW-1:0] cur_ft;
	logic signed [AW-1:0] lead_n;
	logic signed [AW-1:0] lead_n1;
	logic [AW-1:0]        lead_mag;
	logic signed [QW-1:0] quo_s;
	logic signed [XW-1:0] prod_s;
	logic [41:0]          ft_prod;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign div_zero = !div_cap_q && clock_hz_q == '0;
	assign op_mag   = op_q[OW-1] ? OW'(-op_q) : OW'(op_q);
	assign newlow   = (cur_q < lowest_q) ? cur_q : lowest_q;
	assign newu     = (kind_q == ptsc_pkg::KIND_UNKNOWN && ucnt_q < ptsc_pkg::UNKNOWN_LIMIT)
		? ucnt_q + 7'd1 : ucnt_q;
	assign canbase  = !jump_q && base_q == BASE_NONE;
	assign gap_ms   = (GW'(max_gap_q) + GW'(1)) * GW'(ptsc_pkg::MS_PER_S);
	assign gap_lim  = QW'(gap_ms);
	assign jump_now = (quo_q <= NEG_SEC) || (quo_q >= gap_lim);
	assign t_now    = sat_add(now_q, goff_q);
	assign cur_s    = $signed({2'b00, cur_q});
	assign cur_ft   = cur_s - $signed({{(SW-FW){1'b0}}, ft_q});
	assign lead_n   = $signed({2'b00, total_q}) - $signed({{(AW-16){1'b0}}, fsr_q});
	assign lead_n1  = lead_n + AW'(1);
	assign lead_mag = lead_n1[AW-1] ? AW'(-lead_n1) : AW'(lead_n1);
	assign quo_s    = $signed({1'b0, div_quot});
	assign prod_s   = XW'(mul_prod);
	assign ft_prod  = 42'(temporal_ref) * 42'(frame_ticks_q);

	always_comb begin
		div_req.start    = state_q == ST_DIV_GO && !div_zero;
		div_req.dividend = div_cap_q ? DW'(cap_cnt_q) * DW'(ptsc_pkg::CAP_NUM)
			: DW'(op_mag) * DW'(ptsc_pkg::MS_PER_S);
		div_req.divisor  = div_cap_q ? ptsc_pkg::CLK_W'(ptsc_pkg::CAP_DEN) : clock_hz_q;
		mul_req.start    = state_q == ST_MUL_GO;
		mul_req.a        = mul_a_q;
		mul_req.b        = frame_ms_q;
	end

	ptsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	ptsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_off_q    <= 1'b0;
			resync_off_q  <= 1'b0;
			max_gap_q     <= 16'd5;
			clock_hz_q    <= 24'd90000;
			frame_ticks_q <= 32'd196804608;
			frame_ms_q    <= 32'd2187147;
			goff_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptsc_pkg::CFG_SYNC_OFF:    sync_off_q    <= cfg_data[0];
				ptsc_pkg::CFG_RESYNC_OFF:  resync_off_q  <= cfg_data[0];
				ptsc_pkg::CFG_MAX_GAP:     max_gap_q     <= cfg_data[15:0];
				ptsc_pkg::CFG_CLOCK_HZ:    clock_hz_q    <= cfg_data[23:0];
				ptsc_pkg::CFG_FRAME_TICKS: frame_ticks_q <= cfg_data[31:0];
				ptsc_pkg::CFG_FRAME_MS:    frame_ms_q    <= cfg_data[31:0];
				ptsc_pkg::CFG_GLOBAL_OFS:  goff_q        <= clampx(XW'($signed(cfg_data)));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			tref_q    <= temporal_ref;
			kind_q    <= picture_kind;
			fsr_q     <= frames_since_ref;
			total_q   <= total_frames;
			fld_set_q <= caption_field != 2'd0;
			cap_cnt_q <= caption_blocks;
			ft_q      <= ft_prod[41:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cur_q       <= '0;
			phase_q     <= ptsc_pkg::PH_NONE;
			wb_q        <= 1'b0;
			sync_q      <= '0;
			base_q      <= BASE_NONE;
			badj_q      <= 1'b0;
			lowest_q    <= ptsc_pkg::PTS_NONE;
			kts_q       <= 1'b0;
			ucnt_q      <= '0;
			now_q       <= '0;
			max_q       <= '0;
			offset_q    <= '0;
			floor_q     <= '0;
			jump_q      <= 1'b0;
			res_q       <= '0;
			op_q        <= '0;
			div_cap_q   <= 1'b0;
			div_neg_q   <= 1'b0;
			quo_q       <= '0;
			mul_a_q     <= '0;
			mul_neg_q   <= 1'b0;
			fm_q        <= '0;
			cand_q      <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			jump_out_q  <= 1'b0;
			time_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						jump_q <= 1'b0;
						if (req_type == ptsc_pkg::REQ_FRAME) begin
							cur_q <= pts;
							if (phase_q == ptsc_pkg::PH_NONE) phase_q <= ptsc_pkg::PH_RCVD;
							if (pts < cur_q) wb_q <= 1'b1;
							state_q <= ST_JCHK;
						end else begin
							state_q <= ST_QRY;
						end
					end
				end
				ST_JCHK: begin
					if (phase_q == ptsc_pkg::PH_MIN && !sync_off_q) begin
						op_q    <= OW'(cur_s) - OW'(sync_q);
						ret_q   <= ST_JDEC;
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_BADJ;
					end
				end
				ST_JDEC: begin
					if (jump_now) begin
						jump_q <= 1'b1;
						if (tref_q != 10'd0 || kind_q != ptsc_pkg::KIND_I) begin
							now_q   <= max_q;
							res_q   <= sat_add(max_q, goff_q);
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_BADJ;
						end
					end else begin
						state_q <= ST_BADJ;
					end
				end
				ST_BADJ: begin
					if (phase_q == ptsc_pkg::PH_MIN && !badj_q) begin
						if (cur_q[32:30] == 3'd7 && base_q[32:30] == 3'd0) begin
							base_q <= cur_s;
							badj_q <= 1'b1;
						end else if (cur_q[32:30] != 3'd0 && cur_q[32:30] != 3'd7) begin
							badj_q <= 1'b1;
						end
					end
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					if (kind_q != ptsc_pkg::KIND_UNKNOWN) kts_q <= 1'b1;
					lowest_q <= newlow;
					ucnt_q   <= newu;
					state_q  <= ST_RS;
					if (kind_q == ptsc_pkg::KIND_UNKNOWN) begin
						if (newu >= ptsc_pkg::UNKNOWN_LIMIT && !kts_q &&
							newlow != ptsc_pkg::PTS_NONE && canbase) begin
							cand_q  <= newlow;
							state_q <= ST_BASE;
						end
					end else if (kind_q == ptsc_pkg::KIND_I && canbase) begin
						if (newlow != ptsc_pkg::PTS_NONE) begin
							op_q    <= OW'(cur_s) - OW'($signed({2'b00, newlow}));
							ret_q   <= ST_MINDEC;
							state_q <= ST_DIV_GO;
						end else if (cur_q != ptsc_pkg::PTS_NONE) begin
							cand_q  <= cur_q;
							state_q <= ST_BASE;
						end
					end
				end
				ST_MINDEC: begin
					if (quo_q <= GAP_MS) begin
						cand_q  <= lowest_q;
						state_q <= ST_BASE;
					end else begin
						cand_q  <= cur_q;
						state_q <= (cur_q != ptsc_pkg::PTS_NONE) ? ST_BASE : ST_RS;
					end
				end
				ST_BASE: begin
					if (cand_q != ptsc_pkg::PTS_NONE) begin
						base_q  <= $signed({2'b00, cand_q});
						phase_q <= ptsc_pkg::PH_MIN;
						sync_q  <= cur_ft;
						if (tref_q == 10'd0 || lead_n == '0) begin
							offset_q <= '0;
							state_q  <= ST_RS;
						end else begin
							mul_a_q   <= lead_mag;
							mul_neg_q <= lead_n1[AW-1];
							ret_q     <= ST_OFSDEC;
							state_q   <= ST_MUL_GO;
						end
					end else begin
						state_q <= ST_RS;
					end
				end
				ST_OFSDEC: begin
					offset_q <= fm_q;
					state_q  <= ST_RS;
				end
				ST_RS: begin
					if (jump_q && !resync_off_q) begin
						op_q    <= OW'(sync_q) - OW'(base_q);
						ret_q   <= ST_RSDIV;
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_TREF;
					end
				end
				ST_RSDIV: begin
					offset_q  <= sat_add(offset_q, clampx(XW'(quo_q)));
					mul_a_q   <= AW'(fsr_q);
					mul_neg_q <= 1'b0;
					ret_q     <= ST_RSMUL;
					state_q   <= ST_MUL_GO;
				end
				ST_RSMUL: begin
					offset_q <= sat_add(offset_q, fm_q);
					max_q    <= sat_add(offset_q, fm_q);
					sync_q   <= cur_ft;
					base_q   <= cur_ft;
					phase_q  <= ptsc_pkg::PH_MIN;
					state_q  <= ST_TREF;
				end
				ST_TREF: begin
					if (tref_q == 10'd0) sync_q <= cur_s;
					if (phase_q == ptsc_pkg::PH_MIN) begin
						op_q    <= OW'(cur_s) - OW'(base_q);
						ret_q   <= ST_NOWDEC;
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_MAX;
					end
				end
				ST_NOWDEC: begin
					now_q   <= sat_add(clampx(XW'(quo_q)), offset_q);
					state_q <= ST_MAX;
				end
				ST_MAX: begin
					if (wb_q) begin
						floor_q <= '0;
						max_q   <= now_q;
						wb_q    <= 1'b0;
					end else if (now_q > max_q) begin
						max_q <= now_q;
					end
					res_q   <= t_now;
					state_q <= ST_DONE;
				end
				ST_QRY: begin
					state_q <= ST_DONE;
					res_q   <= t_now;
					unique case (req_q)
						ptsc_pkg::REQ_CAPTION: begin
							if (fld_set_q) begin
								div_cap_q <= 1'b1;
								ret_q     <= ST_QCAP;
								state_q   <= ST_DIV_GO;
							end
						end
						ptsc_pkg::REQ_START: begin
							if (t_now <= floor_q) res_q <= sat_add(floor_q, TB'(1));
						end
						ptsc_pkg::REQ_END: begin
							if (t_now > floor_q) floor_q <= t_now;
						end
						default: ;
					endcase
				end
				ST_QCAP: begin
					res_q     <= sat_add(t_now, clampx(XW'(quo_q)));
					div_cap_q <= 1'b0;
					state_q   <= ST_DONE;
				end
				ST_DIV_GO: begin
					div_neg_q <= !div_cap_q && op_q[OW-1];
					if (div_zero) begin
						quo_q   <= '0;
						state_q <= ret_q;
					end else begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						quo_q   <= div_neg_q ? -quo_s : quo_s;
						state_q <= ret_q;
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (mul_done) begin
						fm_q    <= clampx(mul_neg_q ? -prod_s : prod_s);
						state_q <= ret_q;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						ok_q        <= 1'b1;
						jump_out_q  <= jump_q;
						time_q      <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic signed [63:0] time_wide;
	assign time_wide = 64'(time_q);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign jump_seen = jump_out_q;
	assign time_ms   = time_wide[ptsc_pkg::OUT_W-1:0];

	`PTSC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall, "item accepted but block not busy")
	`PTSC_ASSERT_NEXT(a_phase_kept, clk, arst_n, phase_q == ptsc_pkg::PH_MIN, phase_q == ptsc_pkg::PH_MIN, "minimum phase lost")
	`PTSC_ASSERT(a_ucnt_limit, clk, arst_n, ucnt_q <= ptsc_pkg::UNKNOWN_LIMIT, "unknown frame count past limit")
	`PTSC_ASSERT_NEXT(a_query_no_jump, clk, arst_n, accept && req_type != ptsc_pkg::REQ_FRAME, !jump_q, "query flagged a jump")

endmodule

`default_nettype wire
